>>> design/assert_macros.svh
// assertion macros shared by the frustum cull test rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge, quiet while reset is high
`define FC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, including during reset
`define FC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/fcull_pkg.sv
// frustum cull test package: widths, plane and object types, codes
// no dependencies; imported by every frustum cull module
`timescale 1ns / 1ps
`default_nettype none

package fcull_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int PLANE_COUNT    = 6;

   localparam int COEF_WIDTH  = 16;
   localparam int KIND_WIDTH  = 2;
   localparam int EXT_WIDTH   = COORD_WIDTH - 1;
   localparam int INDEX_WIDTH = 3;
   localparam int DATA_WIDTH  = 4 * COEF_WIDTH;

   // signed coefficient times signed coordinate
   localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
   // unsigned extent times coefficient magnitude
   localparam int MAG_WIDTH   = COEF_WIDTH + 1;
   localparam int MPROD_WIDTH = EXT_WIDTH + MAG_WIDTH;
   // wide enough for distance plus margin with guard bits
   localparam int TERM_MAX    =
      (PROD_WIDTH >= COORD_WIDTH - 1 + COEF_FRAC_BITS) ?
         ((PROD_WIDTH >= COEF_WIDTH + COEF_FRAC_BITS) ? PROD_WIDTH
                                                      : COEF_WIDTH + COEF_FRAC_BITS) :
         ((COORD_WIDTH - 1 + COEF_FRAC_BITS >= COEF_WIDTH + COEF_FRAC_BITS) ?
            COORD_WIDTH - 1 + COEF_FRAC_BITS : COEF_WIDTH + COEF_FRAC_BITS);
   localparam int SUM_WIDTH   = TERM_MAX + 4;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_POINT  = 2'd0,
      KIND_SPHERE = 2'd1,
      KIND_BOX    = 2'd2
   } kind_type;

   typedef enum logic [INDEX_WIDTH-1:0] {
      CSR_PLANE_LEFT   = 3'd0,
      CSR_PLANE_RIGHT  = 3'd1,
      CSR_PLANE_TOP    = 3'd2,
      CSR_PLANE_BOTTOM = 3'd3,
      CSR_PLANE_NEAR   = 3'd4,
      CSR_PLANE_FAR    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COEF_WIDTH-1:0] d0;
      logic [COEF_WIDTH-1:0] c;
      logic [COEF_WIDTH-1:0] b;
      logic [COEF_WIDTH-1:0] a;
   } plane_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [COORD_WIDTH-1:0] center_x;
      logic [COORD_WIDTH-1:0] center_y;
      logic [COORD_WIDTH-1:0] center_z;
      logic [EXT_WIDTH-1:0]   radius;
      logic [EXT_WIDTH-1:0]   half_x;
      logic [EXT_WIDTH-1:0]   half_y;
      logic [EXT_WIDTH-1:0]   half_z;
   } object_type;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
   } pipe_ctl_type;

endpackage

`default_nettype wire

>>> design/fcull_planes.sv
// frustum cull plane registers: six 64-bit planes written by the csr port
// depends on fcull_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcull_planes (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         wr_en,
   input  wire logic [fcull_pkg::INDEX_WIDTH-1:0]            wr_index,
   input  wire logic [fcull_pkg::DATA_WIDTH-1:0]             wr_data,
   output      fcull_pkg::plane_type [fcull_pkg::PLANE_COUNT-1:0] planes
);
   import fcull_pkg::*;

   plane_type [PLANE_COUNT-1:0] planes_ff;
   plane_type [PLANE_COUNT-1:0] planes_in;

   always_comb begin
      planes_in = planes_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_PLANE_LEFT:   planes_in[0] = plane_type'(wr_data);
            CSR_PLANE_RIGHT:  planes_in[1] = plane_type'(wr_data);
            CSR_PLANE_TOP:    planes_in[2] = plane_type'(wr_data);
            CSR_PLANE_BOTTOM: planes_in[3] = plane_type'(wr_data);
            CSR_PLANE_NEAR:   planes_in[4] = plane_type'(wr_data);
            CSR_PLANE_FAR:    planes_in[5] = plane_type'(wr_data);
            default:          planes_in = planes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

   assign planes = planes_ff;

endmodule

`default_nettype wire

>>> design/fcull_lane.sv
// frustum cull lane: distance and margin for one plane over two stages
// depends on fcull_pkg; pipeline enables come from the top level
`timescale 1ns / 1ps
`default_nettype none

module fcull_lane (
   input  wire logic                    clock,
   input  wire fcull_pkg::pipe_ctl_type ctl,
   input  wire fcull_pkg::plane_type    plane,
   input  wire fcull_pkg::object_type   obj,
   output      logic                    pass
);
   import fcull_pkg::*;

   logic signed [COORD_WIDTH-1:0] x, y, z;
   logic signed [COEF_WIDTH-1:0]  a, b, c, d0;
   logic signed [MAG_WIDTH-1:0]   a_ext, b_ext, c_ext;
   logic [MAG_WIDTH-1:0]          a_mag, b_mag, c_mag;

   // stage 1: products
   logic signed [PROD_WIDTH-1:0]  px_in, py_in, pz_in;
   logic signed [PROD_WIDTH-1:0]  px_ff, py_ff, pz_ff;
   logic [MPROD_WIDTH-1:0]        mx_in, my_in, mz_in;
   logic [MPROD_WIDTH-1:0]        mx_ff, my_ff, mz_ff;
   logic signed [COEF_WIDTH-1:0]  d0_ff;
   logic [KIND_WIDTH-1:0]         kind_ff;
   logic [EXT_WIDTH-1:0]          radius_ff;

   // stage 2: distance and margin
   logic signed [SUM_WIDTH-1:0]   d_in, m_in, d_ff, m_ff, total;

   always_comb begin
      x     = $signed(obj.center_x);
      y     = $signed(obj.center_y);
      z     = $signed(obj.center_z);
      a     = $signed(plane.a);
      b     = $signed(plane.b);
      c     = $signed(plane.c);
      d0    = $signed(plane.d0);
      a_ext = MAG_WIDTH'(a);
      b_ext = MAG_WIDTH'(b);
      c_ext = MAG_WIDTH'(c);
      a_mag = a[COEF_WIDTH-1] ? MAG_WIDTH'(-a_ext) : MAG_WIDTH'(a_ext);
      b_mag = b[COEF_WIDTH-1] ? MAG_WIDTH'(-b_ext) : MAG_WIDTH'(b_ext);
      c_mag = c[COEF_WIDTH-1] ? MAG_WIDTH'(-c_ext) : MAG_WIDTH'(c_ext);
      px_in = x * a;
      py_in = y * b;
      pz_in = z * c;
      mx_in = MPROD_WIDTH'(obj.half_x) * MPROD_WIDTH'(a_mag);
      my_in = MPROD_WIDTH'(obj.half_y) * MPROD_WIDTH'(b_mag);
      mz_in = MPROD_WIDTH'(obj.half_z) * MPROD_WIDTH'(c_mag);
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         pz_ff     <= pz_in;
         mx_ff     <= mx_in;
         my_ff     <= my_in;
         mz_ff     <= mz_in;
         d0_ff     <= d0;
         kind_ff   <= obj.kind;
         radius_ff <= obj.radius;
      end
   end

   always_comb begin
      d_in = SUM_WIDTH'(px_ff) + SUM_WIDTH'(py_ff) + SUM_WIDTH'(pz_ff)
           + (SUM_WIDTH'(d0_ff) <<< COEF_FRAC_BITS);
      case (kind_ff)
         KIND_SPHERE: m_in = SUM_WIDTH'(radius_ff) << COEF_FRAC_BITS;
         KIND_BOX:    m_in = SUM_WIDTH'(mx_ff) + SUM_WIDTH'(my_ff) + SUM_WIDTH'(mz_ff);
         default:     m_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         d_ff <= d_in;
         m_ff <= m_in;
      end
   end

   // on the plane counts as inside
   assign total = d_ff + m_ff;
   assign pass  = ~total[SUM_WIDTH-1];

endmodule

`default_nettype wire

>>> design/frustum_cull_test_unit.sv
// pipeline: an accepted item moves through s0, s1 and s2 into the result register
// throughput: one item per cycle; each stage moves on when it is empty or its
//   successor moves, so bubbles close up; intake stalls only when all four stages are full
// reset: synchronous, clears all stage valid flags and loads every plane with zero
// depends on fcull_pkg, fcull_planes, fcull_lane and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_test_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [fcull_pkg::KIND_WIDTH-1:0]     req_kind,
   input  wire logic signed [fcull_pkg::COORD_WIDTH-1:0] req_center_x,
   input  wire logic signed [fcull_pkg::COORD_WIDTH-1:0] req_center_y,
   input  wire logic signed [fcull_pkg::COORD_WIDTH-1:0] req_center_z,
   input  wire logic [fcull_pkg::EXT_WIDTH-1:0]      req_radius,
   input  wire logic [fcull_pkg::EXT_WIDTH-1:0]      req_half_x,
   input  wire logic [fcull_pkg::EXT_WIDTH-1:0]      req_half_y,
   input  wire logic [fcull_pkg::EXT_WIDTH-1:0]      req_half_z,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic                                 rsp_visible,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [fcull_pkg::INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [fcull_pkg::DATA_WIDTH-1:0]     csr_wdata
);
   import fcull_pkg::*;
`include "assert_macros.svh"

   plane_type [PLANE_COUNT-1:0] planes;
   object_type                  obj_ff;
   object_type                  obj_in;
   logic                        s0_valid_ff, s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic                        rsp_visible_ff;
   logic                        s0_en, s1_en, s2_en, rsp_en;
   logic [PLANE_COUNT-1:0]      lane_pass;
   pipe_ctl_type                ctl;

   assign csr_ready = 1'b1;

   fcull_planes u_planes (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .planes   (planes)
   );

   // stage enables
   assign rsp_en = ~rsp_valid_ff | ~rsp_stall;
   assign s2_en  = ~s2_valid_ff | rsp_en;
   assign s1_en  = ~s1_valid_ff | s2_en;
   assign s0_en  = ~s0_valid_ff | s1_en;

   assign req_stall = ~s0_en;
   assign ctl.s1_en = s1_en;
   assign ctl.s2_en = s2_en;

   always_comb begin
      obj_in.kind     = req_kind;
      obj_in.center_x = req_center_x;
      obj_in.center_y = req_center_y;
      obj_in.center_z = req_center_z;
      obj_in.radius   = req_radius;
      obj_in.half_x   = req_half_x;
      obj_in.half_y   = req_half_y;
      obj_in.half_z   = req_half_z;
   end

   always_ff @(posedge clock) begin
      if (s0_en) begin
         obj_ff <= obj_in;
      end
      if (rsp_en) begin
         rsp_visible_ff <= &lane_pass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_en) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_en) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rsp_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
      fcull_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .plane (planes[i]),
         .obj   (obj_ff),
         .pass  (lane_pass[i])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   `FC_ASSERT(a_stall_only_when_full,
      req_stall |-> (s0_valid_ff && s1_valid_ff && s2_valid_ff && rsp_valid_ff),
      "input stalled while the pipeline has an empty stage")
   `FC_ASSERT(a_free_output_takes_input,
      !rsp_stall |-> !req_stall,
      "input stalled although the result side is free")
   `FC_ASSERT(a_result_from_stage2,
      (rsp_en && s2_valid_ff) |=> rsp_valid_ff,
      "item in the last stage did not reach the result register")
   `FC_ASSERT_ALWAYS(a_reset_clears_pipe,
      reset |=> (!s0_valid_ff && !s1_valid_ff && !s2_valid_ff && !rsp_valid_ff),
      "pipeline holds an item right after reset")

endmodule

`default_nettype wire
